>>> design/itoa_pkg.sv
// itoa_pkg: shared types, constants and the digit-to-ASCII function for the
// integer-to-ASCII formatter. No dependencies; used by every design file.
package itoa_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_VALUE_BITS  = 64;
  localparam int DEF_SIGNED_BITS = 32;
  localparam int DEF_MAX_RADIX   = 16;

  // Fixed field widths of the stream words
  localparam int VALUE_W     = 64;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;   // digits up to 15 (radix 16) or 9 (decimal)
  localparam int CHAR_W      = 8;
  localparam int IN_TDATA_W  = 72;  // value, radix, upper_case, zero pad
  localparam int TD_RADIX_LSB = VALUE_W;
  localparam int TD_UPPER_BIT = VALUE_W + RADIX_W;

  // Request kinds carried in tuser
  localparam logic REQ_SIGNED   = 1'b0;
  localparam logic REQ_UNSIGNED = 1'b1;

  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;
  localparam logic [RADIX_W-1:0] DEC_RADIX = 5'd10;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;

  // Controls broadcast to every digit cell
  typedef struct packed {
    logic clr;    // start of a new number: zero digits and carries
    logic shift;  // move digits one cell toward the top of the chain
  } cell_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < DIGIT_W'(10)) begin
      digit_char = CH_ZERO + CHAR_W'(d);
    end else begin
      digit_char = base + CHAR_W'(d - DIGIT_W'(10));
    end
  endfunction

endpackage

>>> design/itoa_cell.sv
// itoa_cell: one digit cell of the conversion chain. Doubles its digit and
// adds the carry from the cell below, mod radix; registered carry and step.
// Depends on itoa_pkg.
module itoa_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  itoa_pkg::cell_ctl_t               ctl_i,
  input  logic [itoa_pkg::RADIX_W-1:0]      radix_i,
  input  logic                              step_i,
  input  logic                              carry_i,
  input  logic [itoa_pkg::DIGIT_W-1:0]      digit_i,
  output logic                              step_o,
  output logic                              carry_o,
  output logic [itoa_pkg::DIGIT_W-1:0]      digit_o
);

  logic [itoa_pkg::DIGIT_W-1:0] digit_q, digit_d;
  logic                         step_q, step_d;
  logic                         carry_q, carry_d;
  logic [itoa_pkg::RADIX_W-1:0] dbl;
  logic [itoa_pkg::RADIX_W-1:0] red;
  logic                         ge;

  // 2*d + c is below 2*radix, so one compare and subtract reduces it
  assign dbl = {digit_q, carry_i};
  assign ge  = (dbl >= radix_i);
  assign red = ge ? (dbl - radix_i) : dbl;

  always_comb begin
    digit_d = digit_q;
    step_d  = step_i;
    carry_d = step_i & ge;
    if (ctl_i.clr) begin
      digit_d = '0;
      step_d  = 1'b0;
      carry_d = 1'b0;
    end else if (ctl_i.shift) begin
      digit_d = digit_i;
    end else if (step_i) begin
      digit_d = red[itoa_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 1'b0;
      carry_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign step_o  = step_q;
  assign carry_o = carry_q;
  assign digit_o = digit_q;

endmodule

>>> design/integer_to_ascii_formatter.sv
// Integer to ASCII formatter: one number in, its text out one character per word,
// most significant digit first. N = max(VALUE_BITS, SIGNED_BITS) digit cells.
// Steps: conversion through the cell chain, then an optional minus sign, then the
// digit readout walks all N cells (leading zeros are shifted out unprinted);
// output stalls hold the readout. One number at a time. Reset (rst_ni low, async)
// empties the output register and returns to idle.
module integer_to_ascii_formatter #(
  parameter int VALUE_BITS  = itoa_pkg::DEF_VALUE_BITS,
  parameter int SIGNED_BITS = itoa_pkg::DEF_SIGNED_BITS,
  parameter int MAX_RADIX   = itoa_pkg::DEF_MAX_RADIX
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input words
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [63:0] value, [68:64] radix, [69] upper_case, [71:70] zero
  input  logic [itoa_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // [0] req_type
  input  logic                               s_axis_tuser_i,
  // Output words
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [7:0] char_code
  output logic [itoa_pkg::CHAR_W-1:0]        m_axis_tdata_o,
  // last
  output logic                               m_axis_tlast_o
);

  localparam int NCELL = (VALUE_BITS > SIGNED_BITS) ? VALUE_BITS : SIGNED_BITS;
  localparam int CNT_W = $clog2(2 * NCELL);
  localparam int REM_W = $clog2(NCELL + 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a number
  localparam logic [1:0] ST_CONV = 2'd1;  // bits ripple through the cell chain
  localparam logic [1:0] ST_SIGN = 2'd2;  // emit the minus sign
  localparam logic [1:0] ST_EMIT = 2'd3;  // shift digits out of the top cell

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic             started_q, started_d;
  logic             neg_q, neg_d;
  logic [NCELL-1:0] mag_q, mag_d;
  logic [itoa_pkg::RADIX_W-1:0] radix_q, radix_d;
  logic             upper_q, upper_d;

  logic                       out_valid_q, out_valid_d;
  logic [itoa_pkg::CHAR_W-1:0] out_char_q, out_char_d;
  logic                       out_last_q, out_last_d;

  logic in_acc;
  logic slot_free;
  logic feed;
  logic lead_zero;
  logic load;
  logic [itoa_pkg::CHAR_W-1:0] load_char;
  logic load_last;
  itoa_pkg::cell_ctl_t ctl;

  // Input field decode
  logic [VALUE_BITS-1:0]        in_uval;
  logic [SIGNED_BITS-1:0]       in_sval;
  logic [SIGNED_BITS-1:0]       in_smag;
  logic                         in_neg;
  logic [itoa_pkg::RADIX_W-1:0] in_radix;
  logic [itoa_pkg::RADIX_W-1:0] in_radix_cl;

  // Chain wiring
  logic                         step_w  [NCELL];
  logic                         carry_w [NCELL];
  logic [itoa_pkg::DIGIT_W-1:0] digit_w [NCELL];
  logic [itoa_pkg::DIGIT_W-1:0] top_digit;

  assign in_acc    = s_axis_tvalid_i & s_axis_tready_o;
  assign slot_free = ~out_valid_q | m_axis_tready_i;

  assign in_uval  = s_axis_tdata_i[VALUE_BITS-1:0];
  assign in_sval  = s_axis_tdata_i[SIGNED_BITS-1:0];
  assign in_neg   = in_sval[SIGNED_BITS-1];
  // Two's complement negate in SIGNED_BITS: the most negative value maps onto
  // its own magnitude, read as unsigned.
  assign in_smag  = in_neg ? ((~in_sval) + SIGNED_BITS'(1)) : in_sval;
  assign in_radix = s_axis_tdata_i[itoa_pkg::TD_RADIX_LSB +: itoa_pkg::RADIX_W];

  always_comb begin
    if (in_radix < itoa_pkg::MIN_RADIX) begin
      in_radix_cl = itoa_pkg::MIN_RADIX;
    end else if (in_radix > itoa_pkg::RADIX_W'(MAX_RADIX)) begin
      in_radix_cl = itoa_pkg::RADIX_W'(MAX_RADIX);
    end else begin
      in_radix_cl = in_radix;
    end
  end

  // Operand registers, loaded on accept; magnitude shifts out MSB first
  always_comb begin
    mag_d   = mag_q;
    neg_d   = neg_q;
    radix_d = radix_q;
    upper_d = upper_q;
    if (in_acc) begin
      if (s_axis_tuser_i == itoa_pkg::REQ_SIGNED) begin
        mag_d   = NCELL'(in_smag);
        neg_d   = in_neg;
        radix_d = itoa_pkg::DEC_RADIX;
      end else begin
        mag_d   = NCELL'(in_uval);
        neg_d   = 1'b0;
        radix_d = in_radix_cl;
      end
      upper_d = s_axis_tdata_i[itoa_pkg::TD_UPPER_BIT];
    end else if (feed) begin
      mag_d = {mag_q[NCELL-2:0], 1'b0};
    end
  end

  assign top_digit = digit_w[NCELL-1];
  // Leading zeros are dropped, but the lowest cell always prints (zero -> "0")
  assign lead_zero = ~started_q && (top_digit == '0) && (rem_q != REM_W'(1));

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    started_d = started_q;
    feed      = 1'b0;
    load      = 1'b0;
    load_char = itoa_pkg::CH_ZERO;
    load_last = 1'b0;
    ctl.clr   = in_acc;
    ctl.shift = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_CONV;
          cnt_d   = '0;
        end
      end
      ST_CONV: begin
        // Bits are fed while cnt_q is below N; the state ends once the top cell takes the last bit
        feed  = (cnt_q < CNT_W'(NCELL));
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(2 * NCELL - 2)) begin
          state_d   = neg_q ? ST_SIGN : ST_EMIT;
          rem_d     = REM_W'(NCELL);
          started_d = 1'b0;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = itoa_pkg::CH_MINUS;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (lead_zero) begin
          ctl.shift = 1'b1;
          rem_d     = rem_q - REM_W'(1);
        end else if (slot_free) begin
          load      = 1'b1;
          load_char = itoa_pkg::digit_char(top_digit, upper_q);
          load_last = (rem_q == REM_W'(1));
          ctl.shift = 1'b1;
          rem_d     = rem_q - REM_W'(1);
          started_d = 1'b1;
          if (rem_q == REM_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: holds a finished character while the sink stalls
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_char_d  = load_char;
      out_last_d  = load_last;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      started_q   <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      started_q   <= started_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    radix_q    <= radix_d;
    upper_q    <= upper_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // Digit cell chain: cell 0 holds the least significant digit. Carries and
  // step tokens move up one cell per cycle; on readout digits move up too.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    logic                         step_in;
    logic                         carry_in;
    logic [itoa_pkg::DIGIT_W-1:0] digit_in;

    if (k == 0) begin : g_first
      assign step_in  = feed;
      assign carry_in = feed & mag_q[NCELL-1];
      assign digit_in = '0;
    end else begin : g_next
      assign step_in  = step_w[k-1];
      assign carry_in = carry_w[k-1];
      assign digit_in = digit_w[k-1];
    end

    itoa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .radix_i (radix_q),
      .step_i  (step_in),
      .carry_i (carry_in),
      .digit_i (digit_in),
      .step_o  (step_w[k]),
      .carry_o (carry_w[k]),
      .digit_o (digit_w[k])
    );
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

>>> design/itoa_checker.sv
// itoa_checker: port-level assertions for integer_to_ascii_formatter, and the
// bind that attaches them. Depends on itoa_pkg and the top level.
module itoa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [itoa_pkg::CHAR_W-1:0]     m_axis_tdata_o,
  input logic                            m_axis_tlast_o
);

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // Only digits, letters a-f / A-F or a minus sign are ever produced
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((m_axis_tdata_o >= itoa_pkg::CH_ZERO && m_axis_tdata_o <= itoa_pkg::CH_NINE) ||
       (m_axis_tdata_o >= itoa_pkg::CH_LOWER_A && m_axis_tdata_o <= itoa_pkg::CH_LOWER_F) ||
       (m_axis_tdata_o >= itoa_pkg::CH_UPPER_A && m_axis_tdata_o <= itoa_pkg::CH_UPPER_F) ||
       (m_axis_tdata_o == itoa_pkg::CH_MINUS)))
    else $error("output character outside the digit alphabet");

  // A minus sign always has digits after it
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o == itoa_pkg::CH_MINUS) |-> !m_axis_tlast_o)
    else $error("minus sign flagged as last");

  // One number at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted again during conversion");

  // Ready again only once the final character of the previous number is in the output register
  a_idle_means_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tlast_o)
    else $error("ready while a non-final character is pending");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
